@@ design/fcp_pkg.sv @@
// Shared constants, types and codes for the framed command parser.
// Used by fcp_buffer, fcp_seq and framed_command_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcp_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int POS_W     = $clog2(BUF_DEPTH + 7);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_SYMBOL   = 2'd1;

	localparam logic [7:0] START_RESET = 8'd35;
	localparam logic [7:0] END_RESET   = 8'd33;

	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic KIND_APPEND  = 1'b0;
	localparam logic KIND_PROCESS = 1'b1;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_INCOMPLETE = 3'd1;
	localparam status_t ST_INVALID    = 3'd2;
	localparam status_t ST_CHECKSUM   = 3'd3;
	localparam status_t ST_FORMAT     = 3'd4;

	typedef struct packed {
		status_t status;
		logic    report;
	} res_t;

	typedef struct packed {
		logic       we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

endpackage
`default_nettype wire

@@ design/fcp_buffer.sv @@
// Character buffer: one write port, one read port with registered read data.
// Depends on fcp_pkg for depth and address width.
`timescale 1ns / 1ps
`default_nettype none
module fcp_buffer (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [fcp_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                 wdata,
	input  wire logic [fcp_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                 rdata
);

	logic [7:0] mem [fcp_pkg::BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ design/fcp_seq.sv @@
// Sequencer: buffer fill count, start-symbol scan and frame check, with one
// position compare reused every step. Depends on fcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcp_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fcp_pkg::cfg_t        cfg,
	input  wire logic                 start,
	input  wire logic                 kind,
	input  wire logic [7:0]           byte_value,
	output logic                      idle,
	output logic                      res_valid,
	input  wire logic                 res_take,
	output fcp_pkg::res_t             res,
	output logic [7:0]                gain_p,
	output logic [7:0]                gain_i,
	output logic [7:0]                gain_d
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FETCH, S_EVAL, S_DONE} state_t;
	typedef enum logic [2:0] {F_CMD, F_G1, F_G2, F_G3, F_CSUM, F_END} field_t;

	state_t                       state_q;
	field_t                       field_q;
	logic [fcp_pkg::CNT_W-1:0]    cnt_q;
	logic [fcp_pkg::POS_W-1:0]    pos_q;
	logic [7:0]                   start_q, end_q;
	logic [7:0]                   a_q, b_q, acc_q;
	logic                         dig_ok_q, cmd_p_q;
	fcp_pkg::res_t                res_q;
	logic [7:0]                   gp_q, gi_q, gd_q;
	logic [7:0]                   rdata;
	logic                         in_range;
	logic                         buf_we;
	logic [7:0]                   csum_exp;
	logic [7:0]                   acc_next;

	// shared position compare and accumulator
	assign in_range = pos_q < fcp_pkg::POS_W'(cnt_q);
	assign acc_next = acc_q + rdata;
	assign csum_exp = cmd_p_q ? acc_q : fcp_pkg::CH_S;
	assign buf_we   = start && (kind == fcp_pkg::KIND_APPEND)
	                  && (cnt_q < fcp_pkg::CNT_W'(fcp_pkg::BUF_DEPTH));

	fcp_buffer u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[fcp_pkg::ADDR_W-1:0]),
		.wdata (byte_value),
		.raddr (pos_q[fcp_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign gain_p    = gp_q;
	assign gain_i    = gi_q;
	assign gain_d    = gd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			field_q  <= F_CMD;
			cnt_q    <= '0;
			pos_q    <= '0;
			start_q  <= fcp_pkg::START_RESET;
			end_q    <= fcp_pkg::END_RESET;
			a_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
			dig_ok_q <= 1'b0;
			cmd_p_q  <= 1'b0;
			res_q    <= '0;
			gp_q     <= '0;
			gi_q     <= '0;
			gd_q     <= '0;
		end else begin
			if (cfg.we) begin
				if (cfg.index == fcp_pkg::REG_START_SYMBOL) begin
					start_q <= cfg.data;
				end else if (cfg.index == fcp_pkg::REG_END_SYMBOL) begin
					end_q <= cfg.data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q.report <= 1'b0;
						pos_q        <= '0;
						if (kind == fcp_pkg::KIND_APPEND) begin
							state_q <= S_DONE;
							if (buf_we) begin
								cnt_q        <= cnt_q + fcp_pkg::CNT_W'(1);
								res_q.status <= fcp_pkg::ST_OK;
							end else begin
								res_q.status <= fcp_pkg::ST_INCOMPLETE;
							end
						end else if (cnt_q == '0) begin
							res_q.status <= fcp_pkg::ST_INCOMPLETE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (!in_range) begin
						res_q.status <= fcp_pkg::ST_FORMAT;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					pos_q <= pos_q + fcp_pkg::POS_W'(1);
					if (rdata == start_q) begin
						field_q <= F_CMD;
						state_q <= S_FETCH;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_FETCH: begin
					if (!in_range) begin
						res_q.status <= fcp_pkg::ST_INCOMPLETE;
						state_q      <= S_DONE;
					end else begin
						pos_q   <= pos_q + fcp_pkg::POS_W'(1);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					unique case (field_q)
						F_CMD: begin
							if (rdata == fcp_pkg::CH_P) begin
								cmd_p_q  <= 1'b1;
								acc_q    <= fcp_pkg::CH_P;
								dig_ok_q <= 1'b1;
								field_q  <= F_G1;
								state_q  <= S_FETCH;
							end else if (rdata == fcp_pkg::CH_S) begin
								cmd_p_q <= 1'b0;
								field_q <= F_CSUM;
								state_q <= S_FETCH;
							end else begin
								res_q.status <= fcp_pkg::ST_INVALID;
								state_q      <= S_DONE;
							end
						end
						F_G1: begin
							a_q      <= rdata;
							acc_q    <= acc_next;
							dig_ok_q <= dig_ok_q & fcp_pkg::is_digit(rdata);
							field_q  <= F_G2;
							state_q  <= S_FETCH;
						end
						F_G2: begin
							b_q      <= rdata;
							acc_q    <= acc_next;
							dig_ok_q <= dig_ok_q & fcp_pkg::is_digit(rdata);
							field_q  <= F_G3;
							state_q  <= S_FETCH;
						end
						F_G3: begin
							// store the gains before the digit check
							gp_q  <= a_q;
							gi_q  <= b_q;
							gd_q  <= rdata;
							acc_q <= acc_next;
							if (!(dig_ok_q && fcp_pkg::is_digit(rdata))) begin
								res_q.status <= fcp_pkg::ST_FORMAT;
								state_q      <= S_DONE;
							end else begin
								field_q <= F_CSUM;
								state_q <= S_FETCH;
							end
						end
						F_CSUM: begin
							if (rdata != csum_exp) begin
								res_q.status <= fcp_pkg::ST_CHECKSUM;
								state_q      <= S_DONE;
							end else begin
								field_q <= F_END;
								state_q <= S_FETCH;
							end
						end
						F_END: begin
							state_q <= S_DONE;
							if (rdata != end_q) begin
								res_q.status <= fcp_pkg::ST_INCOMPLETE;
							end else begin
								res_q.status <= fcp_pkg::ST_OK;
								res_q.report <= !cmd_p_q;
								cnt_q        <= '0;
							end
						end
						default: begin
							res_q.status <= fcp_pkg::ST_INVALID;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/framed_command_parser.sv @@
// An append or an empty-buffer parse goes straight to the result; a parse scans positions
// for the start symbol, then fetches and checks the frame bytes one by one.
// One request at a time; the next is taken after the result moves to the output register.
// The buffer's single read port sets the process time.
// Reset (arst_n, async low): empty buffer, gains zero, symbols '#' and '!'.
// Top level: stream ports, input capture and result register; uses fcp_seq.
`timescale 1ns / 1ps
`default_nettype none
module framed_command_parser (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fcp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// byte_value, setpoint_value, plant_output, control_error
	input  wire logic [fcp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// kind
	input  wire logic                              s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// status, gain_p, gain_i, gain_d, report_setpoint, report_output,
	// report_error, zero fill
	output logic      [fcp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// report_valid
	output logic                                   m_axis_tuser
);

	fcp_pkg::cfg_t  cfg;
	fcp_pkg::res_t  res;
	logic           accept, idle, res_valid, res_take;
	logic [7:0]     gain_p, gain_i, gain_d;
	logic [15:0]    sp_q, po_q, ce_q;
	logic           out_valid_q;
	logic [fcp_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic           out_user_q;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign res_take      = res_valid && (!out_valid_q || m_axis_tready);

	fcp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (accept),
		.kind       (s_axis_tuser),
		.byte_value (s_axis_tdata[7:0]),
		.idle       (idle),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.gain_p     (gain_p),
		.gain_i     (gain_i),
		.gain_d     (gain_d)
	);

	// hold the controller values of the request
	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q <= s_axis_tdata[23:8];
			po_q <= s_axis_tdata[39:24];
			ce_q <= s_axis_tdata[55:40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_user_q  <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_user_q  <= res.report;
				out_data_q  <= {5'b0,
				                res.report ? ce_q : 16'h0,
				                res.report ? po_q : 16'h0,
				                res.report ? sp_q : 16'h0,
				                gain_d, gain_i, gain_p, res.status};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef ASSERT_OFF
	a_report_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == fcp_pkg::ST_OK)
		else $error("report flagged on a failed request");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[74:27] == '0)
		else $error("report fields not cleared");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request taken while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(out_data_q) && out_valid_q)
		else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for framed_command_parser: streams byte appends and parse requests,
// predicts every reply with an in-bench parser model and compares field by field.
// Depends on fcp_pkg and the framed_command_parser design sources.
module tb_top;
	import fcp_pkg::*;

	localparam int CFG_GAP     = 4;
	localparam int TAIL_CYCLES = 64;
	localparam int MAX_JUNK    = 3;
	localparam int P_FRAME_LEN = 7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {
		FAULT_NONE, FAULT_CUT, FAULT_DIGIT, FAULT_SUM, FAULT_END, FAULT_LETTER
	} frame_fault_t;

	typedef struct {
		logic        kind;
		logic [7:0]  byte_value;
		logic [15:0] setpoint_value;
		logic [15:0] plant_output;
		logic [15:0] control_error;
	} parser_req_t;

	typedef struct {
		status_t     status;
		logic [7:0]  gain_p;
		logic [7:0]  gain_i;
		logic [7:0]  gain_d;
		logic        report_valid;
		logic [15:0] report_setpoint;
		logic [15:0] report_output;
		logic [15:0] report_error;
	} parser_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	parser_req_t   request_fifo[$];
	parser_reply_t expected_replies[$];
	int queued_total = 0;
	int accepted_total = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int good_frames = 0;
	int reg_writes = 0;
	int send_idle_pct = 32;
	int recv_idle_pct = 50;
	int hold_off_left = 0;

	// parser model state
	logic [7:0] line_buf [BUF_DEPTH];
	int         line_count = 0;
	logic [7:0] model_gain_p = '0;
	logic [7:0] model_gain_i = '0;
	logic [7:0] model_gain_d = '0;
	logic [7:0] start_sym = START_RESET;
	logic [7:0] end_sym = END_RESET;

	framed_command_parser dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit frame_byte(input int pos, output logic [7:0] c);
		c = 8'h00;
		if (pos >= line_count) return 1'b0;
		c = line_buf[pos];
		return 1'b1;
	endfunction

	// Parse the first frame in the line buffer; gains and count change as in the block.
	function automatic status_t parse_line(output bit report);
		int s;
		logic [7:0] c, a, b, d, sum;
		report = 1'b0;
		if (line_count == 0) return ST_INCOMPLETE;
		s = 0;
		while (s < line_count && line_buf[s] != start_sym) s++;
		if (s >= line_count) return ST_FORMAT;
		if (!frame_byte(s + 1, c)) return ST_INCOMPLETE;
		if (c == CH_P) begin
			if (!frame_byte(s + 2, a)) return ST_INCOMPLETE;
			if (!frame_byte(s + 3, b)) return ST_INCOMPLETE;
			if (!frame_byte(s + 4, d)) return ST_INCOMPLETE;
			// gains latch before the digits are checked
			model_gain_p = a;
			model_gain_i = b;
			model_gain_d = d;
			if (a < CH_0 || a > CH_9 || b < CH_0 || b > CH_9 || d < CH_0 || d > CH_9)
				return ST_FORMAT;
			if (!frame_byte(s + 5, c)) return ST_INCOMPLETE;
			sum = CH_P + a + b + d;
			if (c != sum) return ST_CHECKSUM;
			if (!frame_byte(s + 6, c)) return ST_INCOMPLETE;
			if (c != end_sym) return ST_INCOMPLETE;
			line_count = 0;
			return ST_OK;
		end
		if (c == CH_S) begin
			if (!frame_byte(s + 2, c)) return ST_INCOMPLETE;
			if (c != CH_S) return ST_CHECKSUM;
			if (!frame_byte(s + 3, c)) return ST_INCOMPLETE;
			if (c != end_sym) return ST_INCOMPLETE;
			line_count = 0;
			report = 1'b1;
			return ST_OK;
		end
		return ST_INVALID;
	endfunction

	function automatic parser_reply_t predict_reply(input parser_req_t r);
		parser_reply_t p;
		bit report;
		report = 1'b0;
		if (r.kind == KIND_APPEND) begin
			if (line_count < BUF_DEPTH) begin
				line_buf[line_count] = r.byte_value;
				line_count++;
				p.status = ST_OK;
			end else begin
				p.status = ST_INCOMPLETE;
			end
		end else begin
			p.status = parse_line(report);
			if (p.status == ST_OK) good_frames++;
		end
		p.gain_p = model_gain_p;
		p.gain_i = model_gain_i;
		p.gain_d = model_gain_d;
		p.report_valid = report;
		p.report_setpoint = report ? r.setpoint_value : 16'h0000;
		p.report_output = report ? r.plant_output : 16'h0000;
		p.report_error = report ? r.control_error : 16'h0000;
		return p;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] want,
	                                    input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	// request driver: valid drops only between requests
	initial begin : request_driver
		parser_req_t r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (request_fifo.size() == 0 || $urandom_range(99) < send_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				r = request_fifo.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {r.control_error, r.plant_output, r.setpoint_value,
				                 r.byte_value};
				s_axis_tuser <= r.kind;
				@(posedge clk);
				while (!s_axis_tready) @(posedge clk);
				expected_replies.push_back(predict_reply(r));
				accepted_total++;
			end
		end
	end

	initial begin : reply_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : reply_check
		parser_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			replies_seen++;
			if (expected_replies.size() == 0) begin
				$error("reply with no request outstanding: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 16'(want.status), 16'(m_axis_tdata[2:0]));
				check_field("gain_p", 16'(want.gain_p), 16'(m_axis_tdata[10:3]));
				check_field("gain_i", 16'(want.gain_i), 16'(m_axis_tdata[18:11]));
				check_field("gain_d", 16'(want.gain_d), 16'(m_axis_tdata[26:19]));
				check_field("report_setpoint", want.report_setpoint, m_axis_tdata[42:27]);
				check_field("report_output", want.report_output, m_axis_tdata[58:43]);
				check_field("report_error", want.report_error, m_axis_tdata[74:59]);
				check_field("zero fill", 16'h0000, 16'(m_axis_tdata[79:75]));
				check_field("report_valid", 16'(want.report_valid), 16'(m_axis_tuser));
			end
		end
	end

	function automatic parser_req_t rand_req(input logic kind, input logic [7:0] value);
		parser_req_t r;
		r.kind = kind;
		r.byte_value = value;
		r.setpoint_value = 16'($urandom);
		r.plant_output = 16'($urandom);
		r.control_error = 16'($urandom);
		return r;
	endfunction

	function automatic void post(input parser_req_t r);
		request_fifo.push_back(r);
		queued_total++;
	endfunction

	function automatic void add_byte(input logic [7:0] value);
		post(rand_req(KIND_APPEND, value));
	endfunction

	function automatic void ask_parse();
		post(rand_req(KIND_PROCESS, 8'($urandom)));
	endfunction

	function automatic logic [7:0] pick_symbol();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Hold until every queued request has its reply.
	task automatic drain();
		while (accepted_total != queued_total || expected_replies.size() != 0)
			@(posedge clk);
		repeat (CFG_GAP) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		if (idx == REG_START_SYMBOL)
			start_sym = value;
		else if (idx == REG_END_SYMBOL)
			end_sym = value;
	endtask

	// Junk without the start symbol, one frame (damaged as asked), optional extra bytes,
	// then the parse request. Parse requests are sprinkled between frame bytes.
	function automatic void queue_frame(input logic [7:0] letter, input frame_fault_t fault,
	                                    input int junk_len, input int extra_len);
		logic [7:0] seq[$];
		logic [7:0] dig[3];
		logic [7:0] c;
		int keep, i;
		repeat (junk_len) begin
			do c = 8'($urandom); while (c == start_sym);
			seq.push_back(c);
		end
		seq.push_back(start_sym);
		if (fault == FAULT_LETTER) begin
			do c = 8'($urandom); while (c == CH_P || c == CH_S);
			seq.push_back(c);
			repeat ($urandom_range(3)) seq.push_back(8'($urandom));
		end else begin
			seq.push_back(letter);
			if (letter == CH_P) begin
				for (i = 0; i < 3; i++) dig[i] = CH_0 + 8'($urandom_range(9));
				if (fault == FAULT_DIGIT) begin
					do c = 8'($urandom); while (c >= CH_0 && c <= CH_9);
					dig[$urandom_range(2)] = c;
				end
				c = CH_P + dig[0] + dig[1] + dig[2];
				for (i = 0; i < 3; i++) seq.push_back(dig[i]);
			end else begin
				c = CH_S;
			end
			if (fault == FAULT_SUM) c ^= 8'($urandom_range(1, 255));
			seq.push_back(c);
			c = end_sym;
			if (fault == FAULT_END) c ^= 8'($urandom_range(1, 255));
			seq.push_back(c);
		end
		if (fault == FAULT_CUT) begin
			keep = $urandom_range(junk_len + 1, seq.size() - 1);
			while (seq.size() > keep) void'(seq.pop_back());
		end
		for (i = 0; i < seq.size(); i++) begin
			if (i > 0 && $urandom_range(99) < 12) ask_parse();
			add_byte(seq[i]);
		end
		repeat (extra_len) add_byte(8'($urandom));
		ask_parse();
	endfunction

	function automatic void queue_noise(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 30)
				ask_parse();
			else if (roll < 45)
				add_byte(start_sym);
			else if (roll < 55)
				add_byte($urandom_range(1) ? CH_P : CH_S);
			else
				add_byte(8'($urandom));
		end
	endfunction

	// A failed frame stays in the buffer; move the start symbol to a value not in it
	// and close a status frame behind it so the buffer empties.
	task automatic clear_line();
		logic [7:0] fresh;
		bit seen;
		int k;
		if (line_count == 0) return;
		do begin
			fresh = 8'($urandom);
			seen = 1'b0;
			for (k = 0; k < line_count; k++)
				if (line_buf[k] == fresh) seen = 1'b1;
		end while (seen);
		set_reg(REG_START_SYMBOL, fresh);
		add_byte(fresh);
		add_byte(CH_S);
		add_byte(CH_S);
		add_byte(end_sym);
		ask_parse();
		drain();
	endtask

	task automatic test_empty_and_unframed();
		ask_parse();
		add_byte(8'h00);
		add_byte(8'hFF);
		ask_parse();
		add_byte(START_RESET);
		ask_parse();
		drain();
	endtask

	task automatic test_gain_command();
		add_byte(CH_P);
		add_byte(CH_0 + 8'd1);
		add_byte(CH_0 + 8'd2);
		ask_parse();
		add_byte(CH_0 + 8'd3);
		ask_parse();
		add_byte(CH_P + CH_0 + CH_0 + CH_0 + 8'd6);
		add_byte(END_RESET);
		ask_parse();
		drain();
	endtask

	task automatic test_status_report();
		parser_req_t r;
		add_byte(START_RESET);
		add_byte(CH_S);
		add_byte(CH_S);
		add_byte(END_RESET);
		r = rand_req(KIND_PROCESS, 8'h00);
		r.setpoint_value = 16'h8000;
		r.plant_output = 16'h7FFF;
		r.control_error = 16'hFFFF;
		post(r);
		drain();
	endtask

	task automatic test_bad_letter_and_registers();
		add_byte(START_RESET);
		add_byte("Q");
		ask_parse();
		drain();
		// unused indexes must not disturb either symbol
		set_reg(REG_SPARE_2, 8'h00);
		set_reg(REG_SPARE_3, 8'hFF);
		set_reg(REG_START_SYMBOL, 8'h00);
		set_reg(REG_END_SYMBOL, 8'hFF);
		add_byte(8'h00);
		add_byte(CH_S);
		add_byte(CH_S);
		add_byte(8'hFF);
		ask_parse();
		drain();
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
		int goal, pick;
		frame_fault_t fault;
		logic [7:0] letter;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal = queued_total + n_items;
		while (queued_total < goal) begin
			if ($urandom_range(99) < 20) set_reg(REG_START_SYMBOL, pick_symbol());
			if ($urandom_range(99) < 15) set_reg(REG_END_SYMBOL, pick_symbol());
			if ($urandom_range(99) < 3)
				set_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 8'($urandom));
			pick = $urandom_range(99);
			letter = $urandom_range(1) ? CH_P : CH_S;
			if (pick < 55) begin
				queue_frame(letter, FAULT_NONE, $urandom_range(MAX_JUNK), 0);
			end else if (pick < 82) begin
				fault = frame_fault_t'($urandom_range(FAULT_CUT, FAULT_LETTER));
				if (fault == FAULT_DIGIT) letter = CH_P;
				queue_frame(letter, fault, $urandom_range(MAX_JUNK), 0);
			end else if (pick < 93) begin
				queue_noise($urandom_range(1, 10));
			end else begin
				// fill the buffer exactly, then push bytes it must drop
				queue_frame(CH_P, FAULT_NONE, BUF_DEPTH - P_FRAME_LEN, $urandom_range(1, 3));
			end
			drain();
			clear_line();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain();
		hold_off_left = 300;
		repeat (6)
			queue_frame($urandom_range(1) ? CH_P : CH_S, FAULT_NONE,
			            $urandom_range(MAX_JUNK), 0);
		drain();
	endtask

	initial begin : main_sequence
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_unframed();
		test_gain_command();
		test_status_report();
		test_bad_letter_and_registers();
		run_random_phase(32, 50, 430);
		run_random_phase(50, 32, 430);
		run_random_phase(0, 0, 430);
		test_backpressure();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d requests checked against %0d replies, %0d frames parsed clean",
		         accepted_total, replies_seen, good_frames);
		$display("%0d register writes over both symbols, extremes and unused indexes",
		         reg_writes);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
design/fcp_pkg.sv
design/fcp_buffer.sv
design/fcp_seq.sv
design/framed_command_parser.sv
bench/tb_top.sv
